// File: rtl/core/msrt_pkg.sv
package msrt_pkg;

	localparam int DATA_W = 32;

	typedef struct packed {
		logic signed [DATA_W-1:0] value;
		logic                     last_in;
	} in_item_t;

	typedef struct packed {
		logic signed [DATA_W-1:0] sorted_value;
		logic                     last_out;
		logic                     overflow;
	} out_item_t;

	typedef enum logic [2:0] {
		ST_LOAD,
		ST_SETUP,
		ST_MERGE,
		ST_OSETUP,
		ST_OUT
	} st_t;

	// write strobes per buffer and which buffer is the read source
	typedef struct packed {
		logic we_main;
		logic we_merge;
		logic rd_merge;
	} ram_ctrl_t;

endpackage

// File: rtl/core/msrt_ram.sv
module msrt_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr_a,
	input  logic [AW-1:0]    raddr_b,
	output logic [WIDTH-1:0] rdata_a,
	output logic [WIDTH-1:0] rdata_b
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_a <= mem[raddr_a];
		rdata_b <= mem[raddr_b];
	end

endmodule

// File: rtl/core/msrt_ctrl.sv
module msrt_ctrl #(
	parameter int MAX_ITEMS = 64,
	localparam int AW = $clog2(MAX_ITEMS),
	localparam int CNT_W = $clog2(MAX_ITEMS + 1)
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          item_valid,
	output logic                          item_ready,
	input  msrt_pkg::in_item_t            item,
	output logic                          result_valid,
	input  logic                          result_ready,
	output msrt_pkg::out_item_t           result,
	input  logic signed [msrt_pkg::DATA_W-1:0] rd_a,
	input  logic signed [msrt_pkg::DATA_W-1:0] rd_b,
	output logic [AW-1:0]                 raddr_a,
	output logic [AW-1:0]                 raddr_b,
	output logic [AW-1:0]                 waddr,
	output logic [msrt_pkg::DATA_W-1:0]   wdata,
	output msrt_pkg::ram_ctrl_t           ram_ctrl
);

	import msrt_pkg::*;

	localparam int SUM_W = CNT_W + 2;

	st_t              state_q, state_d;
	logic [CNT_W-1:0] cnt_q, cnt_d, i_q, i_d, j_q, j_d;
	logic [CNT_W-1:0] mid_q, mid_d, hi_q, hi_d, k_q, k_d;
	logic [SUM_W-1:0] w_q, w_d;
	logic             drop_q, drop_d, src_q, src_d;

	logic             item_acc, res_acc, has_room, res_last;
	logic             a_ok, b_ok, take_b, blk_done, pass_done, sort_done;
	logic [CNT_W-1:0] cnt_ld, i_adv, j_adv, n_start, mid_nx, hi_nx, mid0, hi0;
	logic [SUM_W-1:0] w_dbl, w_start, sum_mid, sum_hi, sum_mid0, sum_hi0;

	assign item_acc = item_valid && item_ready;
	assign res_acc  = result_valid && result_ready;
	assign has_room = cnt_q < CNT_W'(MAX_ITEMS);
	assign cnt_ld   = has_room ? cnt_q + CNT_W'(1) : cnt_q;
	assign res_last = k_q == cnt_q - CNT_W'(1);

	// merge step: pick the smaller head, left side wins ties
	assign a_ok   = i_q < mid_q;
	assign b_ok   = j_q < hi_q;
	assign take_b = b_ok && (!a_ok || (rd_b < rd_a));
	assign i_adv  = take_b ? i_q : i_q + CNT_W'(1);
	assign j_adv  = take_b ? j_q + CNT_W'(1) : j_q;

	assign blk_done  = (i_adv == mid_q) && (j_adv == hi_q);
	assign pass_done = blk_done && (hi_q == cnt_q);
	assign w_dbl     = w_q << 1;
	assign sort_done = w_dbl >= SUM_W'(cnt_q);

	// bounds of the next block within a pass
	assign sum_mid = SUM_W'(hi_q) + w_q;
	assign sum_hi  = SUM_W'(hi_q) + w_dbl;
	assign mid_nx  = (sum_mid > SUM_W'(cnt_q)) ? cnt_q : sum_mid[CNT_W-1:0];
	assign hi_nx   = (sum_hi > SUM_W'(cnt_q)) ? cnt_q : sum_hi[CNT_W-1:0];

	// bounds of the first block of a new pass
	assign w_start  = (state_q == ST_LOAD) ? SUM_W'(1) : w_dbl;
	assign n_start  = (state_q == ST_LOAD) ? cnt_ld : cnt_q;
	assign sum_mid0 = w_start;
	assign sum_hi0  = w_start << 1;
	assign mid0     = (sum_mid0 > SUM_W'(n_start)) ? n_start : sum_mid0[CNT_W-1:0];
	assign hi0      = (sum_hi0 > SUM_W'(n_start)) ? n_start : sum_hi0[CNT_W-1:0];

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_LOAD: begin
				if (item_acc && item.last_in) begin
					state_d = (cnt_ld >= CNT_W'(2)) ? ST_SETUP : ST_OSETUP;
				end
			end
			ST_SETUP: begin
				state_d = ST_MERGE;
			end
			ST_MERGE: begin
				if (pass_done) begin
					state_d = sort_done ? ST_OSETUP : ST_SETUP;
				end
			end
			ST_OSETUP: begin
				state_d = ST_OUT;
			end
			ST_OUT: begin
				if (res_acc && res_last) begin
					state_d = ST_LOAD;
				end
			end
		endcase
	end

	// pointers and counters
	always_comb begin
		cnt_d  = cnt_q;
		drop_d = drop_q;
		src_d  = src_q;
		w_d    = w_q;
		i_d    = i_q;
		j_d    = j_q;
		mid_d  = mid_q;
		hi_d   = hi_q;
		k_d    = k_q;
		unique case (state_q)
			ST_LOAD: begin
				if (item_acc) begin
					cnt_d = cnt_ld;
					if (!has_room) begin
						drop_d = 1'b1;
					end
					if (item.last_in) begin
						src_d = 1'b0;
						w_d   = SUM_W'(1);
						i_d   = '0;
						j_d   = mid0;
						mid_d = mid0;
						hi_d  = hi0;
						k_d   = '0;
					end
				end
			end
			ST_MERGE: begin
				k_d = k_q + CNT_W'(1);
				if (pass_done) begin
					src_d = !src_q;
					w_d   = w_dbl;
					i_d   = '0;
					j_d   = mid0;
					mid_d = mid0;
					hi_d  = hi0;
					k_d   = '0;
				end else if (blk_done) begin
					i_d   = hi_q;
					j_d   = mid_nx;
					mid_d = mid_nx;
					hi_d  = hi_nx;
				end else begin
					i_d = i_adv;
					j_d = j_adv;
				end
			end
			ST_OUT: begin
				if (res_acc) begin
					if (res_last) begin
						cnt_d  = '0;
						drop_d = 1'b0;
						k_d    = '0;
					end else begin
						k_d = k_q + CNT_W'(1);
					end
				end
			end
			ST_SETUP, ST_OSETUP: begin
			end
		endcase
	end

	// outputs
	always_comb begin
		item_ready        = state_q == ST_LOAD;
		result_valid      = state_q == ST_OUT;
		ram_ctrl.rd_merge = src_q;
		ram_ctrl.we_main  = 1'b0;
		ram_ctrl.we_merge = 1'b0;
		waddr             = k_q[AW-1:0];
		wdata             = take_b ? rd_b : rd_a;
		// addresses follow the next pointer so the read data lines up with it
		raddr_a           = i_d[AW-1:0];
		raddr_b           = j_d[AW-1:0];
		unique case (state_q)
			ST_LOAD: begin
				ram_ctrl.we_main = item_acc && has_room;
				waddr            = cnt_q[AW-1:0];
				wdata            = item.value;
			end
			ST_MERGE: begin
				ram_ctrl.we_main  = src_q;
				ram_ctrl.we_merge = !src_q;
			end
			ST_OSETUP, ST_OUT: begin
				raddr_a = k_d[AW-1:0];
			end
			ST_SETUP: begin
			end
		endcase
		result.sorted_value = rd_a;
		result.last_out     = res_last;
		result.overflow     = drop_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_LOAD;
			cnt_q   <= '0;
			drop_q  <= 1'b0;
			src_q   <= 1'b0;
			w_q     <= '0;
			i_q     <= '0;
			j_q     <= '0;
			mid_q   <= '0;
			hi_q    <= '0;
			k_q     <= '0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
			drop_q  <= drop_d;
			src_q   <= src_d;
			w_q     <= w_d;
			i_q     <= i_d;
			j_q     <= j_d;
			mid_q   <= mid_d;
			hi_q    <= hi_d;
			k_q     <= k_d;
		end
	end

endmodule

// File: rtl/core/merge_sorter_top.sv
// channel  | signals                             | moves
// ---------+-------------------------------------+------------------------------------
// item     | item_valid, item_ready, item        | one value per transfer, last_in ends
// result   | result_valid, result_ready, result  | one sorted value per transfer
//
// load accepts one item per cycle; after the last item there are ceil(log2 n) merge
// passes over the n stored values, each a setup state then one value written per cycle,
// set by the single write port of the destination buffer; output passes through a setup
// state, then gives one result per cycle while result_ready is high.
// reset clears the control state only; the buffers hold no reset value.
// a stall on result simply holds the read address, so the payload stays put.
module merge_sorter_top #(
	parameter int MAX_ITEMS = 64
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                item_valid,
	output logic                item_ready,
	input  msrt_pkg::in_item_t  item,
	output logic                result_valid,
	input  logic                result_ready,
	output msrt_pkg::out_item_t result
);

	import msrt_pkg::*;

	localparam int AW = $clog2(MAX_ITEMS);

	// shared address and data buses into both buffers
	logic [AW-1:0]            raddr_a, raddr_b, waddr;
	logic [DATA_W-1:0]        wdata;
	logic [DATA_W-1:0]        main_rd_a, main_rd_b, mrg_rd_a, mrg_rd_b;
	logic signed [DATA_W-1:0] rd_a, rd_b;
	ram_ctrl_t                ram_ctrl;

	// main buffer: filled during load, destination on even passes
	msrt_ram #(
		.WIDTH(DATA_W),
		.DEPTH(MAX_ITEMS)
	) u_main_ram (
		.clk    (clk),
		.we     (ram_ctrl.we_main),
		.waddr  (waddr),
		.wdata  (wdata),
		.raddr_a(raddr_a),
		.raddr_b(raddr_b),
		.rdata_a(main_rd_a),
		.rdata_b(main_rd_b)
	);

	// merge buffer: the other half of the ping-pong pair
	msrt_ram #(
		.WIDTH(DATA_W),
		.DEPTH(MAX_ITEMS)
	) u_merge_ram (
		.clk    (clk),
		.we     (ram_ctrl.we_merge),
		.waddr  (waddr),
		.wdata  (wdata),
		.raddr_a(raddr_a),
		.raddr_b(raddr_b),
		.rdata_a(mrg_rd_a),
		.rdata_b(mrg_rd_b)
	);

	// source buffer of the current pass, or the one holding the sorted run
	assign rd_a = ram_ctrl.rd_merge ? mrg_rd_a : main_rd_a;
	assign rd_b = ram_ctrl.rd_merge ? mrg_rd_b : main_rd_b;

	msrt_ctrl #(
		.MAX_ITEMS(MAX_ITEMS)
	) u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.item_valid  (item_valid),
		.item_ready  (item_ready),
		.item        (item),
		.result_valid(result_valid),
		.result_ready(result_ready),
		.result      (result),
		.rd_a        (rd_a),
		.rd_b        (rd_b),
		.raddr_a     (raddr_a),
		.raddr_b     (raddr_b),
		.waddr       (waddr),
		.wdata       (wdata),
		.ram_ctrl    (ram_ctrl)
	);

endmodule
